FILE: design/srdz_pkg.sv
// Shared types and constants of the stick radial dead-zone core.
`timescale 1ns / 1ps
package srdz_pkg;

   localparam int FRAC_BITS     = 15;
   localparam int FRAC_W        = FRAC_BITS + 1;
   localparam int SEARCH_STAGES = FRAC_BITS + 1;
   localparam int LANES         = 6;
   localparam int STICKS        = 2;
   localparam int AXES          = 4;

   localparam logic [14:0] FULL_SCALE      = 15'd32767;
   localparam logic [14:0] LEFT_DZ_RESET   = 15'd7849;
   localparam logic [14:0] RIGHT_DZ_RESET  = 15'd8689;

   localparam logic CSR_LEFT_DZ  = 1'b0;
   localparam logic CSR_RIGHT_DZ = 1'b1;

   localparam int LANE_LEVEL = 0;
   localparam int LANE_X     = 1;
   localparam int LANE_Y     = 2;

   typedef struct packed {
      logic signed [15:0] left_x;
      logic signed [15:0] left_y;
      logic signed [15:0] right_x;
      logic signed [15:0] right_y;
      logic               pad_connected;
   } srdz_req_type;

   typedef struct packed {
      logic signed [15:0] left_out_x;
      logic signed [15:0] left_out_y;
      logic        [14:0] left_level;
      logic signed [15:0] right_out_x;
      logic signed [15:0] right_out_y;
      logic        [14:0] right_level;
   } srdz_rsp_type;

   // One bit search: largest c with c*c*k2 + 2*c*k1 + k0 <= lim.
   typedef struct packed {
      logic [FRAC_W-1:0] c;
      logic [63:0]       t;
      logic [47:0]       u;
      logic [31:0]       k2;
      logic [63:0]       lim;
   } lane_type;

   typedef lane_type [LANES-1:0] lane_set_type;

   typedef struct packed {
      logic [AXES-1:0]   neg;
      logic [STICKS-1:0] dead;
      logic              connected;
   } side_type;

endpackage

FILE: design/srdz_prep.sv
// Input stages: squares, dead-zone products and search lane setup.
`timescale 1ns / 1ps
module srdz_prep (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  srdz_pkg::srdz_req_type  in_data,
   input  logic [14:0]             left_dz,
   input  logic [14:0]             right_dz,
   output logic                    out_valid,
   input  logic                    out_ready,
   output srdz_pkg::lane_set_type  out_lanes,
   output srdz_pkg::side_type      out_side
);
   import srdz_pkg::*;

   logic [15:0] raw [AXES];
   logic [14:0] dz [STICKS];

   logic [31:0] sq_ff [AXES];
   logic [31:0] sq_in [AXES];
   logic [29:0] dz2_ff [STICKS];
   logic [29:0] dz2_in [STICKS];
   logic [29:0] span2_ff [STICKS];
   logic [29:0] span2_in [STICKS];
   logic [29:0] dspan_ff [STICKS];
   logic [29:0] dspan_in [STICKS];
   logic [STICKS-1:0] dzfull_ff, dzfull_in;
   logic [AXES-1:0] neg_ff, neg_in;
   logic conn_ff;
   logic valid1_ff, valid2_ff;
   logic ready1;
   lane_set_type lanes_ff, lanes_in;
   side_type side_ff, side_in;

   assign raw[0] = in_data.left_x;
   assign raw[1] = in_data.left_y;
   assign raw[2] = in_data.right_x;
   assign raw[3] = in_data.right_y;
   assign dz[0] = left_dz;
   assign dz[1] = right_dz;

   assign ready1   = !valid2_ff || out_ready;
   assign in_ready = !valid1_ff || ready1;

   always_comb begin
      logic [15:0] mag;
      logic [14:0] span;
      for (int i = 0; i < AXES; i++) begin
         neg_in[i] = raw[i][15];
         mag = raw[i][15] ? 16'(-raw[i]) : raw[i];
         sq_in[i] = 32'(mag) * 32'(mag);
      end
      for (int s = 0; s < STICKS; s++) begin
         span = FULL_SCALE - dz[s];
         dz2_in[s]   = 30'(dz[s]) * 30'(dz[s]);
         span2_in[s] = 30'(span) * 30'(span);
         dspan_in[s] = 30'(dz[s]) * 30'(span);
         dzfull_in[s] = (dz[s] == FULL_SCALE);
      end
   end

   always_comb begin
      logic [31:0] r2;
      side_in.neg = neg_ff;
      side_in.connected = conn_ff;
      for (int s = 0; s < STICKS; s++) begin
         r2 = sq_ff[2*s] + sq_ff[2*s+1];
         side_in.dead[s] = dzfull_ff[s] || (r2 <= 32'(dz2_ff[s]));
         lanes_in[3*s+LANE_LEVEL].c   = '0;
         lanes_in[3*s+LANE_LEVEL].t   = 64'(dz2_ff[s]) << 30;
         lanes_in[3*s+LANE_LEVEL].u   = 48'(dspan_ff[s]) << FRAC_BITS;
         lanes_in[3*s+LANE_LEVEL].k2  = 32'(span2_ff[s]);
         lanes_in[3*s+LANE_LEVEL].lim = 64'(r2) << 30;
         lanes_in[3*s+LANE_X].c   = '0;
         lanes_in[3*s+LANE_X].t   = '0;
         lanes_in[3*s+LANE_X].u   = '0;
         lanes_in[3*s+LANE_X].k2  = r2;
         lanes_in[3*s+LANE_X].lim = 64'(sq_ff[2*s]) << 30;
         lanes_in[3*s+LANE_Y].c   = '0;
         lanes_in[3*s+LANE_Y].t   = '0;
         lanes_in[3*s+LANE_Y].u   = '0;
         lanes_in[3*s+LANE_Y].k2  = r2;
         lanes_in[3*s+LANE_Y].lim = 64'(sq_ff[2*s+1]) << 30;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
      end else begin
         if (in_ready) valid1_ff <= in_valid;
         if (ready1) valid2_ff <= valid1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         sq_ff     <= sq_in;
         dz2_ff    <= dz2_in;
         span2_ff  <= span2_in;
         dspan_ff  <= dspan_in;
         dzfull_ff <= dzfull_in;
         neg_ff    <= neg_in;
         conn_ff   <= in_data.pad_connected;
      end
      if (ready1 && valid1_ff) begin
         lanes_ff <= lanes_in;
         side_ff  <= side_in;
      end
   end

   assign out_valid = valid2_ff;
   assign out_lanes = lanes_ff;
   assign out_side  = side_ff;

endmodule

FILE: design/srdz_search_stage.sv
// One bit of the six parallel square-root quotient searches.
`timescale 1ns / 1ps
module srdz_search_stage (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [3:0]              bit_idx,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  srdz_pkg::lane_set_type  in_lanes,
   input  srdz_pkg::side_type      in_side,
   output logic                    out_valid,
   input  logic                    out_ready,
   output srdz_pkg::lane_set_type  out_lanes,
   output srdz_pkg::side_type      out_side
);
   import srdz_pkg::*;

   logic valid_ff;
   lane_set_type lanes_ff, lanes_in;
   side_type side_ff;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      logic [63:0] cand;
      logic [4:0] sh_u;
      logic [4:0] sh_k;
      sh_u = {1'b0, bit_idx} + 5'd1;
      sh_k = {bit_idx, 1'b0};
      lanes_in = in_lanes;
      for (int l = 0; l < LANES; l++) begin
         cand = in_lanes[l].t + (64'(in_lanes[l].u) << sh_u)
              + (64'(in_lanes[l].k2) << sh_k);
         if (!in_lanes[l].c[FRAC_W-1] && cand <= in_lanes[l].lim) begin
            lanes_in[l].c = in_lanes[l].c | (FRAC_W'(1) << bit_idx);
            lanes_in[l].t = cand;
            lanes_in[l].u = in_lanes[l].u + (48'(in_lanes[l].k2) << bit_idx);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         lanes_ff <= lanes_in;
         side_ff  <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_lanes = lanes_ff;
   assign out_side  = side_ff;

endmodule

FILE: design/srdz_post.sv
// Output stages: direction times level, saturation, sign and zeroing.
`timescale 1ns / 1ps
module srdz_post (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  srdz_pkg::lane_set_type  in_lanes,
   input  srdz_pkg::side_type      in_side,
   output logic                    out_valid,
   input  logic                    out_ready,
   output srdz_pkg::srdz_rsp_type  out_data
);
   import srdz_pkg::*;

   logic [FRAC_W-1:0] lev_ff [STICKS];
   logic [FRAC_W-1:0] lev_in [STICKS];
   logic [31:0] prod_ff [AXES];
   logic [31:0] prod_in [AXES];
   side_type side_ff;
   logic valid1_ff, valid2_ff;
   logic ready1;
   srdz_rsp_type rsp_ff, rsp_in;

   assign ready1   = !valid2_ff || out_ready;
   assign in_ready = !valid1_ff || ready1;

   always_comb begin
      for (int s = 0; s < STICKS; s++) begin
         lev_in[s] = in_lanes[3*s+LANE_LEVEL].c;
         prod_in[2*s]   = 32'(in_lanes[3*s+LANE_X].c) * 32'(in_lanes[3*s+LANE_LEVEL].c);
         prod_in[2*s+1] = 32'(in_lanes[3*s+LANE_Y].c) * 32'(in_lanes[3*s+LANE_LEVEL].c);
      end
   end

   always_comb begin
      logic [15:0] axis [AXES];
      logic [14:0] level [STICKS];
      logic [16:0] mag;
      logic [15:0] val;
      logic live;
      for (int i = 0; i < AXES; i++) begin
         mag = prod_ff[i][31:15];
         val = (mag > 17'(FULL_SCALE)) ? {1'b0, FULL_SCALE} : mag[15:0];
         live = side_ff.connected && !side_ff.dead[i/2];
         axis[i] = !live ? 16'd0 : (side_ff.neg[i] ? 16'(-val) : val);
      end
      for (int s = 0; s < STICKS; s++) begin
         live = side_ff.connected && !side_ff.dead[s];
         level[s] = !live ? 15'd0
                  : (lev_ff[s] > FRAC_W'(FULL_SCALE)) ? FULL_SCALE : lev_ff[s][14:0];
      end
      rsp_in.left_out_x  = axis[0];
      rsp_in.left_out_y  = axis[1];
      rsp_in.left_level  = level[0];
      rsp_in.right_out_x = axis[2];
      rsp_in.right_out_y = axis[3];
      rsp_in.right_level = level[1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
      end else begin
         if (in_ready) valid1_ff <= in_valid;
         if (ready1) valid2_ff <= valid1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         lev_ff  <= lev_in;
         prod_ff <= prod_in;
         side_ff <= in_side;
      end
      if (ready1 && valid1_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   assign out_valid = valid2_ff;
   assign out_data  = rsp_ff;

endmodule

FILE: design/stick_radial_dead_zone_core.sv
// Top level of the two-stick circular dead-zone conditioning core.
`timescale 1ns / 1ps
// The core takes one request per clock while the output does not stall:
// two input stages form the squares and dead-zone products, sixteen stages
// each settle one bit of the level and direction quotients by an exact
// shift-and-add square-root compare, and two output stages scale, saturate
// and sign the axes. Bubbles close up under backpressure, so the core keeps
// accepting while a response waits, until every stage is full. Dead-zone
// writes take effect for requests accepted after them.
module stick_radial_dead_zone_core (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  srdz_pkg::srdz_req_type  req_data,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output srdz_pkg::srdz_rsp_type  rsp_data,
   input  logic                    csr_wr_en,
   input  logic                    csr_index,
   input  logic [14:0]             csr_wdata
);
   import srdz_pkg::*;

   logic [14:0] left_dz_ff, right_dz_ff;

   logic         valid_w [SEARCH_STAGES+1];
   logic         ready_w [SEARCH_STAGES+1];
   lane_set_type lanes_w [SEARCH_STAGES+1];
   side_type     side_w  [SEARCH_STAGES+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         left_dz_ff  <= LEFT_DZ_RESET;
         right_dz_ff <= RIGHT_DZ_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_LEFT_DZ:  left_dz_ff  <= csr_wdata;
            CSR_RIGHT_DZ: right_dz_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   srdz_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (req_data),
      .left_dz   (left_dz_ff),
      .right_dz  (right_dz_ff),
      .out_valid (valid_w[0]),
      .out_ready (ready_w[0]),
      .out_lanes (lanes_w[0]),
      .out_side  (side_w[0])
   );

   for (genvar g = 0; g < SEARCH_STAGES; g++) begin : g_search
      srdz_search_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .bit_idx   (4'(SEARCH_STAGES - 1 - g)),
         .in_valid  (valid_w[g]),
         .in_ready  (ready_w[g]),
         .in_lanes  (lanes_w[g]),
         .in_side   (side_w[g]),
         .out_valid (valid_w[g+1]),
         .out_ready (ready_w[g+1]),
         .out_lanes (lanes_w[g+1]),
         .out_side  (side_w[g+1])
      );
   end

   srdz_post u_post (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (valid_w[SEARCH_STAGES]),
      .in_ready  (ready_w[SEARCH_STAGES]),
      .in_lanes  (lanes_w[SEARCH_STAGES]),
      .in_side   (side_w[SEARCH_STAGES]),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_data)
   );

endmodule
